@@ rtl/pec_pkg.sv @@
// ----------------------------------------------------------------------------
// pec_pkg
// Shared types, constants and register codes of the power easing curve block.
// ----------------------------------------------------------------------------
package pec_pkg;

  localparam int DEF_TIME_BITS  = 16;
  localparam int DEF_VALUE_BITS = 24;

  // normalised time and shape factor are unsigned q0.16, one extra bit holds 1.0
  localparam int FRAC_BITS = 16;
  localparam int Q_W       = FRAC_BITS + 1;

  typedef logic [Q_W-1:0] q_t;

  localparam q_t ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [Q_W:0] TWO_Q = {ONE_Q, 1'b0};

  localparam int CFG_IDX_BITS = 3;
  localparam int POW_BITS     = 3;

  localparam logic [POW_BITS-1:0] POW_MIN = 3'd2;
  localparam logic [POW_BITS-1:0] POW_MAX = 3'd5;

  // one multiply stage per product of the highest power
  localparam int MUL_STAGES = int'(POW_MAX) - 1;

  // pipeline depths: one setup stage plus one quotient bit per stage
  localparam int DIV_STAGES = FRAC_BITS + 1;
  // operand select, products, shape factor, scale, offset
  localparam int SHP_STAGES = MUL_STAGES + 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START    = 3'd0,
    REG_CHANGE   = 3'd1,
    REG_DURATION = 3'd2,
    REG_POWER    = 3'd3,
    REG_MODE     = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EASE_IN    = 2'd0,
    EASE_OUT   = 2'd1,
    EASE_INOUT = 2'd2
  } ease_mode_t;

endpackage

@@ rtl/pec_if.sv @@
// ----------------------------------------------------------------------------
// pec_if
// Valid/ready channels of the power easing curve block: time in, value out,
// register writes.
// ----------------------------------------------------------------------------
interface pec_in_if import pec_pkg::*; #(
  parameter int TIME_BITS = DEF_TIME_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] elapsed_time;

  modport source (output valid, output elapsed_time, input ready);
  modport sink   (input valid, input elapsed_time, output ready);
endinterface

interface pec_out_if import pec_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS:0]   eased_value;
  logic                         at_end;

  modport source (output valid, output eased_value, output at_end, input ready);
  modport sink   (input valid, input eased_value, input at_end, output ready);
endinterface

interface pec_cfg_if import pec_pkg::*; #(
  parameter int DATA_BITS = DEF_VALUE_BITS
) ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [DATA_BITS-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/pec_div.sv @@
// ----------------------------------------------------------------------------
// pec_div
// Pipelined restoring divider: clamps the time to the duration and forms
// u = t * 2^16 / d in q0.16, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pec_div import pec_pkg::*; #(
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic [TIME_BITS-1:0]  t_in,
  input  logic [TIME_BITS-1:0]  dur,
  output q_t                    u,
  output logic                  at_end
);

  localparam int LAST = DIV_STAGES - 1;

  logic [TIME_BITS-1:0] rem_r [DIV_STAGES];
  logic [FRAC_BITS-1:0] q_r   [DIV_STAGES];
  logic                 end_r [DIV_STAGES];

  logic                 end_nxt;

  assign end_nxt = (t_in >= dur);

  // setup stage: a clamped time gives exactly 1.0, so the division runs on zero
  always_ff @(posedge clk) begin
    if (en[0]) begin
      end_r[0] <= end_nxt;
      rem_r[0] <= end_nxt ? '0 : t_in;
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_bit
    logic [TIME_BITS:0] dbl;
    logic [TIME_BITS:0] diff;
    logic               ge;

    assign dbl  = {rem_r[k-1], 1'b0};
    assign ge   = (dbl >= {1'b0, dur});
    assign diff = dbl - {1'b0, dur};

    // remainder stays below the duration, so it fits the time width
    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= ge ? diff[TIME_BITS-1:0] : dbl[TIME_BITS-1:0];
        q_r[k]   <= {q_r[k-1][FRAC_BITS-2:0], ge};
        end_r[k] <= end_r[k-1];
      end
    end
  end

  assign u      = end_r[LAST] ? ONE_Q : {1'b0, q_r[LAST]};
  assign at_end = end_r[LAST];

endmodule

@@ rtl/pec_shape.sv @@
// ----------------------------------------------------------------------------
// pec_shape
// Shape factor and scaling: picks the power base for the easing mode, raises
// it by repeated truncating products, folds it into the shape factor and
// scales it onto start and change.
// ----------------------------------------------------------------------------
module pec_shape import pec_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                         clk,
  input  logic [SHP_STAGES-1:0]        en,
  input  q_t                           u,
  input  logic                         end_in,
  input  logic [POW_BITS-1:0]          power,
  input  ease_mode_t                   mode,
  input  logic signed [VALUE_BITS-1:0] start,
  input  logic signed [VALUE_BITS-1:0] change,
  output logic signed [VALUE_BITS:0]   eased_value,
  output logic                         at_end
);

  localparam int S_F   = MUL_STAGES + 1;
  localparam int S_MUL = MUL_STAGES + 2;
  localparam int S_OUT = MUL_STAGES + 3;
  localparam int PW    = VALUE_BITS + Q_W + 1;

  q_t   acc_r [MUL_STAGES+1];
  q_t   x_r   [MUL_STAGES];
  logic hi_r  [MUL_STAGES+1];
  logic end_r [SHP_STAGES];

  q_t                          f_r;
  q_t                          f_nxt;
  q_t                          x_nxt;
  logic                        hi_nxt;
  logic [Q_W:0]                s2;
  logic signed [PW-1:0]        prod_r;
  logic signed [PW-1:0]        prod_nxt;
  logic signed [VALUE_BITS+1:0] sum_nxt;
  logic signed [VALUE_BITS:0]  eased_r;

  // base of the power; in-out runs on twice the time and mirrors the upper half
  assign s2 = {u, 1'b0};

  always_comb begin
    x_nxt  = u;
    hi_nxt = 1'b0;
    unique case (mode)
      EASE_IN:  x_nxt = u;
      EASE_OUT: x_nxt = ONE_Q - u;
      EASE_INOUT: begin
        if (s2 < {1'b0, ONE_Q}) begin
          x_nxt = s2[Q_W-1:0];
        end else begin
          x_nxt  = Q_W'(TWO_Q - s2);
          hi_nxt = 1'b1;
        end
      end
      default: x_nxt = u;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r[0]   <= x_nxt;
      acc_r[0] <= x_nxt;
      hi_r[0]  <= hi_nxt;
      end_r[0] <= end_in;
    end
  end

  // product k is taken only while k is below the power, else the value rides along
  for (genvar k = 1; k <= MUL_STAGES; k++) begin : g_mul
    logic [2*Q_W-1:0] prod;

    assign prod = acc_r[k-1] * x_r[k-1];

    always_ff @(posedge clk) begin
      if (en[k]) begin
        acc_r[k] <= (power > POW_BITS'(k)) ? prod[FRAC_BITS +: Q_W] : acc_r[k-1];
        hi_r[k]  <= hi_r[k-1];
        end_r[k] <= end_r[k-1];
      end
    end

    if (k < MUL_STAGES) begin : g_x
      always_ff @(posedge clk) begin
        if (en[k]) begin
          x_r[k] <= x_r[k-1];
        end
      end
    end
  end

  always_comb begin
    f_nxt = acc_r[MUL_STAGES];
    unique case (mode)
      EASE_IN:  f_nxt = acc_r[MUL_STAGES];
      EASE_OUT: f_nxt = ONE_Q - acc_r[MUL_STAGES];
      EASE_INOUT: begin
        if (hi_r[MUL_STAGES]) begin
          f_nxt = ONE_Q - (acc_r[MUL_STAGES] >> 1);
        end else begin
          f_nxt = acc_r[MUL_STAGES] >> 1;
        end
      end
      default: f_nxt = acc_r[MUL_STAGES];
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[S_F]) begin
      f_r        <= f_nxt;
      end_r[S_F] <= end_r[S_F-1];
    end
  end

  assign prod_nxt = change * $signed({1'b0, f_r});

  always_ff @(posedge clk) begin
    if (en[S_MUL]) begin
      prod_r       <= prod_nxt;
      end_r[S_MUL] <= end_r[S_MUL-1];
    end
  end

  // arithmetic shift floors the scaled change
  assign sum_nxt = $signed(prod_r[PW-1:FRAC_BITS]) + start;

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      eased_r      <= sum_nxt[VALUE_BITS:0];
      end_r[S_OUT] <= end_r[S_OUT-1];
    end
  end

  assign eased_value = eased_r;
  assign at_end      = end_r[S_OUT];

endmodule

@@ rtl/power_easing_curve_top.sv @@
// ----------------------------------------------------------------------------
// power_easing_curve_top
// Polynomial easing (quadratic to quintic, in / out / in-out) over a clamped,
// normalised time, scaled onto a start value and a change amount.
//
//   channel  dir  transfer carries
//   in_ch    in   elapsed_time
//   out_ch   out  eased_value, at_end
//   cfg_ch   in   index, data (register write, always ready)
//
// One item per cycle while the result is taken; the pipeline depth is set by
// the one-bit-per-stage divider and the four product stages of the power.
// Reset clears the stage valid bits and loads the register defaults.
// A stalled result holds the output stage; earlier stages keep moving into
// empty slots, so input is taken until every stage holds an item.
// ----------------------------------------------------------------------------
module power_easing_curve_top import pec_pkg::*; #(
  parameter int TIME_BITS  = DEF_TIME_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  pec_in_if.sink        in_ch,
  pec_out_if.source     out_ch,
  pec_cfg_if.sink       cfg_ch
);

  localparam int NS = DIV_STAGES + SHP_STAGES;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS-1:0] en;

  logic signed [VALUE_BITS-1:0] start_r;
  logic signed [VALUE_BITS-1:0] start_nxt;
  logic signed [VALUE_BITS-1:0] change_r;
  logic signed [VALUE_BITS-1:0] change_nxt;
  logic [TIME_BITS-1:0]         dur_r;
  logic [TIME_BITS-1:0]         dur_nxt;
  logic [POW_BITS-1:0]          pwr_r;
  logic [POW_BITS-1:0]          pwr_nxt;
  logic [POW_BITS-1:0]          pwr_wr;
  ease_mode_t                   mode_r;
  ease_mode_t                   mode_nxt;

  q_t   u;
  logic div_end;

  // register writes, normalised as they land
  assign cfg_ch.ready = 1'b1;
  assign pwr_wr       = cfg_ch.data[POW_BITS-1:0];

  always_comb begin
    start_nxt  = start_r;
    change_nxt = change_r;
    dur_nxt    = dur_r;
    pwr_nxt    = pwr_r;
    mode_nxt   = mode_r;
    if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_START:  start_nxt  = cfg_ch.data[VALUE_BITS-1:0];
        REG_CHANGE: change_nxt = cfg_ch.data[VALUE_BITS-1:0];
        REG_DURATION: begin
          dur_nxt = (cfg_ch.data[TIME_BITS-1:0] == '0) ? TIME_BITS'(1)
                                                       : cfg_ch.data[TIME_BITS-1:0];
        end
        REG_POWER: begin
          priority if (pwr_wr < POW_MIN) pwr_nxt = POW_MIN;
          else if (pwr_wr > POW_MAX)     pwr_nxt = POW_MAX;
          else                           pwr_nxt = pwr_wr;
        end
        REG_MODE: begin
          mode_nxt = (cfg_ch.data[1:0] > EASE_INOUT) ? EASE_INOUT
                                                     : ease_mode_t'(cfg_ch.data[1:0]);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      change_r <= '0;
      dur_r    <= TIME_BITS'(1);
      pwr_r    <= POW_MIN;
      mode_r   <= EASE_IN;
    end else begin
      start_r  <= start_nxt;
      change_r <= change_nxt;
      dur_r    <= dur_nxt;
      pwr_r    <= pwr_nxt;
      mode_r   <= mode_nxt;
    end
  end

  // a stage moves when it or any stage after it is empty; when it and every
  // stage after it are full, only if the output is being taken
  for (genvar i = 0; i < NS; i++) begin : g_en
    assign en[i] = !(&v_r[NS-1:i]) || out_ch.ready;
  end

  always_comb begin
    v_nxt[0] = en[0] ? in_ch.valid : v_r[0];
    for (int i = 1; i < NS; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready  = en[0];
  assign out_ch.valid = v_r[NS-1];

  pec_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk    (clk),
    .en     (en[DIV_STAGES-1:0]),
    .t_in   (in_ch.elapsed_time),
    .dur    (dur_r),
    .u      (u),
    .at_end (div_end)
  );

  pec_shape #(
    .VALUE_BITS (VALUE_BITS)
  ) u_shape (
    .clk         (clk),
    .en          (en[NS-1:DIV_STAGES]),
    .u           (u),
    .end_in      (div_end),
    .power       (pwr_r),
    .mode        (mode_r),
    .start       (start_r),
    .change      (change_r),
    .eased_value (out_ch.eased_value),
    .at_end      (out_ch.at_end)
  );

  // an accepted time lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v_r[0])
    else $error("accepted item missing from first stage");

  // input is refused only with every stage occupied
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r))
    else $error("input blocked with an empty stage");

  // stored power and duration stay in their working range
  a_cfg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pwr_r >= POW_MIN) && (pwr_r <= POW_MAX) && (dur_r != '0))
    else $error("power or duration register out of range");

endmodule

@@ tb/sv/eased_value_checker.sv @@
// ----------------------------------------------------------------------------
// eased_value_checker
// Watches the time, result and register channels of the easing curve block,
// keeps its own copy of the curve registers, predicts the eased value and
// end flag of every accepted time sample and compares each result in order.
// ----------------------------------------------------------------------------
module eased_value_checker import pec_pkg::*; #(
  parameter int TIME_BITS  = DEF_TIME_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [TIME_BITS-1:0]       in_elapsed_time,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [VALUE_BITS:0] out_eased_value,
  input  logic                       out_at_end,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [VALUE_BITS-1:0]      cfg_data,
  output int                         mismatch_count,
  output int                         in_flight,
  output int                         results_seen
);

  localparam longint unsigned UNIT   = ONE_Q;
  localparam longint unsigned DOUBLE = TWO_Q;

  typedef struct packed {
    logic [TIME_BITS-1:0]       elapsed;
    logic signed [VALUE_BITS:0] value;
    logic                       at_end;
  } curve_point_t;

  logic signed [VALUE_BITS-1:0] start_q;
  logic signed [VALUE_BITS-1:0] change_q;
  logic [TIME_BITS-1:0]         duration_q;
  logic [POW_BITS-1:0]          power_q;
  logic [1:0]                   mode_q;

  curve_point_t pending_points[$];

  // x^deg in q16, truncating after every product
  function automatic longint unsigned q16_power(input longint unsigned x,
                                                input int unsigned deg);
    longint unsigned acc;
    acc = x;
    for (int unsigned k = 1; k < deg; k++) acc = (acc * x) >> FRAC_BITS;
    return acc;
  endfunction

  function automatic curve_point_t eased_point(input logic [TIME_BITS-1:0] t);
    longint unsigned d, tc, u, twice, shape;
    longint          scaled;
    int unsigned     deg;
    curve_point_t    pt;
    d = (duration_q == '0) ? 1 : duration_q;
    if (power_q < POW_MIN)      deg = POW_MIN;
    else if (power_q > POW_MAX) deg = POW_MAX;
    else                        deg = power_q;
    pt.elapsed = t;
    pt.at_end  = (t >= d);
    tc = pt.at_end ? d : t;
    u  = (tc << FRAC_BITS) / d;
    if (mode_q == EASE_IN) begin
      shape = q16_power(u, deg);
    end else if (mode_q == EASE_OUT) begin
      shape = UNIT - q16_power(UNIT - u, deg);
    end else begin
      // in-out, the spare mode code behaves the same
      twice = u * 2;
      if (twice < UNIT) shape = q16_power(twice, deg) >> 1;
      else              shape = UNIT - (q16_power(DOUBLE - twice, deg) >> 1);
    end
    scaled   = longint'(change_q) * longint'(shape);
    pt.value = (VALUE_BITS+1)'(longint'(start_q) + (scaled >>> FRAC_BITS));
    return pt;
  endfunction

  always @(posedge clk) begin
    curve_point_t want;
    int bad;
    bad = 0;
    if (!rst_n) begin
      start_q    = '0;
      change_q   = '0;
      duration_q = TIME_BITS'(1);
      power_q    = POW_MIN;
      mode_q     = EASE_IN;
      pending_points.delete();
      mismatch_count <= 0;
      in_flight      <= 0;
      results_seen   <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_points.size() == 0) begin
          $display("%0t: result transfer with nothing outstanding: eased_value %0d at_end %0b",
                   $time, out_eased_value, out_at_end);
          bad++;
        end else begin
          want = pending_points.pop_front();
          if (out_eased_value !== want.value) begin
            $display("%0t: eased_value for elapsed %0d: expected %0d, got %0d",
                     $time, want.elapsed, $signed(want.value), out_eased_value);
            bad++;
          end
          if (out_at_end !== want.at_end) begin
            $display("%0t: at_end for elapsed %0d: expected %0b, got %0b",
                     $time, want.elapsed, want.at_end, out_at_end);
            bad++;
          end
        end
        results_seen <= results_seen + 1;
      end
      // predict with the registers as they stood before this edge
      if (in_valid && in_ready) pending_points.push_back(eased_point(in_elapsed_time));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START:    start_q    = cfg_data;
          REG_CHANGE:   change_q   = cfg_data;
          REG_DURATION: duration_q = cfg_data[TIME_BITS-1:0];
          REG_POWER:    power_q    = cfg_data[POW_BITS-1:0];
          REG_MODE:     mode_q     = cfg_data[1:0];
          default: ;
        endcase
      end
      mismatch_count <= mismatch_count + bad;
      in_flight      <= pending_points.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives the easing curve block through directed corner cases and randomised
// curve settings with bursty input, a stalling result sink and long sink
// hold-offs; the checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_top import pec_pkg::*;;

  localparam int TB = DEF_TIME_BITS;
  localparam int VB = DEF_VALUE_BITS;

  localparam int PIPE_LATENCY = DIV_STAGES + SHP_STAGES;
  localparam int ITEM_TARGET  = 1950;
  localparam int LONG_HOLD    = 200;
  localparam int STALL_LIMIT  = 2000;

  localparam logic [VB-1:0] VAL_MAX    = {1'b0, {(VB-1){1'b1}}};
  localparam logic [VB-1:0] VAL_MIN    = {1'b1, {(VB-1){1'b0}}};
  localparam logic [1:0]    EASE_SPARE = 2'd3;

  typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_TOGGLE} sink_style_t;

  logic clk;
  logic rst_n;

  int items_sent      = 0;
  int settings_loaded = 0;
  int stray_writes    = 0;
  int hold_asks       = 0;
  int idle_cycles     = 0;
  int unsigned span   = 1;

  int mismatch_count;
  int in_flight;
  int results_seen;

  pec_in_if  #(.TIME_BITS(TB))  in_ch  ();
  pec_out_if #(.VALUE_BITS(VB)) out_ch ();
  pec_cfg_if #(.DATA_BITS(VB))  cfg_ch ();

  power_easing_curve_top #(.TIME_BITS(TB), .VALUE_BITS(VB)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  eased_value_checker #(.TIME_BITS(TB), .VALUE_BITS(VB)) value_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_elapsed_time (in_ch.elapsed_time),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_eased_value (out_ch.eased_value),
    .out_at_end      (out_ch.at_end),
    .cfg_valid       (cfg_ch.valid),
    .cfg_ready       (cfg_ch.ready),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .mismatch_count  (mismatch_count),
    .in_flight       (in_flight),
    .results_seen    (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic push_time(input logic [TB-1:0] t);
    in_ch.valid        <= 1'b1;
    in_ch.elapsed_time <= t;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [VB-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // stop offering and wait for every outstanding result
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  task automatic load_curve(input logic [VB-1:0] start_v, input logic [VB-1:0] change_v,
                            input logic [TB-1:0] dur, input logic [POW_BITS-1:0] deg,
                            input logic [1:0] mode, input bit junk);
    logic [VB-1:0] noise;
    noise = junk ? VB'($urandom) : '0;
    cfg_write(REG_START, start_v);
    cfg_write(REG_CHANGE, change_v);
    cfg_write(REG_DURATION, {noise[VB-1:TB], dur});
    cfg_write(REG_POWER, {noise[VB-1:POW_BITS], deg});
    cfg_write(REG_MODE, {noise[VB-1:2], mode});
    // a write past the last register must change nothing
    if (junk) begin
      cfg_write(CFG_IDX_BITS'(int'(REG_MODE) + 1 + $urandom_range(0, 2)), VB'($urandom));
      stray_writes++;
    end
    cfg_ch.valid <= 1'b0;
    span = (dur == '0) ? 1 : dur;
    settings_loaded++;
  endtask

  function automatic logic [VB-1:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return VB'($urandom_range(0, 512)) - VB'(256);
      default: return VB'($urandom);
    endcase
  endfunction

  initial begin : receiver
    sink_style_t style;
    int seg_left, hold_left, holds_served;
    style        = SINK_OPEN;
    seg_left     = 0;
    hold_left    = 0;
    holds_served = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_served != hold_asks) begin
        hold_left = LONG_HOLD;
        holds_served++;
      end
      if (seg_left == 0) begin
        style    = sink_style_t'($urandom_range(0, 3));
        seg_left = $urandom_range(10, 150);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (style)
          SINK_OPEN:   out_ch.ready <= 1'b1;
          SINK_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:     out_ch.ready <= ~out_ch.ready;
        endcase
      end
    end
  end

  // ends the run when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned     probe[$];
    int              phase_no, phase_len, burst_left;
    bit              steady;
    logic [TB-1:0]   dur, t;
    logic [POW_BITS-1:0] deg;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.elapsed_time = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults: no change, one-tick duration
    probe = '{0, 1, 65535};
    foreach (probe[k]) push_time(TB'(probe[k]));
    finish_phase();

    // largest positive swing, longest duration, quintic ease in
    load_curve(VAL_MAX, VAL_MAX, '1, POW_MAX, EASE_IN, 1'b0);
    probe = '{0, 32768, 65534, 65535};
    foreach (probe[k]) push_time(TB'(probe[k]));
    finish_phase();

    // zero duration acts as one tick, power below range acts as quadratic
    load_curve(VAL_MIN, VAL_MAX, '0, '0, EASE_OUT, 1'b0);
    probe = '{0, 1, 2};
    foreach (probe[k]) push_time(TB'(probe[k]));
    finish_phase();

    // spare mode code acts as in-out, power above range acts as quintic
    load_curve(VB'(1000), VB'(-123457), TB'(100), '1, EASE_SPARE, 1'b0);
    probe = '{0, 49, 50, 51, 100, 101};
    foreach (probe[k]) push_time(TB'(probe[k]));
    finish_phase();

    load_curve('0, VAL_MAX, TB'(1000), POW_BITS'(3), EASE_INOUT, 1'b1);
    probe = '{250, 500, 750};
    foreach (probe[k]) push_time(TB'(probe[k]));
    finish_phase();

    // most negative start and change reach the bottom of the output range
    load_curve(VAL_MIN, VAL_MIN, TB'(7), POW_BITS'(1), EASE_OUT, 1'b0);
    probe = '{3, 6, 7};
    foreach (probe[k]) push_time(TB'(probe[k]));
    finish_phase();

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      phase_no++;
      case ($urandom_range(0, 7))
        0:       dur = '0;
        1:       dur = '1;
        2:       dur = TB'($urandom_range(1, 16));
        3:       dur = TB'($urandom_range(17, 400));
        default: dur = TB'($urandom);
      endcase
      if ($urandom_range(0, 4) == 0) deg = POW_BITS'($urandom_range(0, 7));
      else                           deg = POW_BITS'($urandom_range(POW_MIN, POW_MAX));
      load_curve(pick_level(), pick_level(), dur, deg, 2'($urandom_range(0, 3)),
                 $urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 110);
      steady    = ($urandom_range(0, 3) == 0);
      // keep offering while the sink holds off, so the pipeline fills and backs up
      if (phase_no % 9 == 3) begin
        hold_asks <= hold_asks + 1;
        phase_len = 160;
        steady    = 1'b1;
      end
      burst_left = $urandom_range(1, 40);
      repeat (phase_len) begin
        case ($urandom_range(0, 9))
          0:       t = TB'($urandom);
          1:       t = '0;
          2:       t = TB'(span - 1);
          3:       t = TB'(span);
          4:       t = TB'(span + 1);
          default: t = TB'($urandom_range(0, span));
        endcase
        push_time(t);
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if (!steady) begin
            in_ch.valid        <= 1'b0;
            in_ch.elapsed_time <= TB'($urandom);
            repeat ($urandom_range(1, 15)) @(posedge clk);
          end
        end
      end
      finish_phase();
    end

    repeat (PIPE_LATENCY + 5) @(posedge clk);
    $display("run covered %0d time samples over %0d curve settings, %0d results compared",
             items_sent, settings_loaded, results_seen);
    $display("with %0d stray register writes and %0d long sink hold-offs",
             stray_writes, hold_asks);
    if (mismatch_count == 0 && in_flight == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/pec_pkg.sv
rtl/pec_if.sv
rtl/pec_div.sv
rtl/pec_shape.sv
rtl/power_easing_curve_top.sv
tb/sv/eased_value_checker.sv
tb/sv/tb_top.sv
